### sv/epl_pkg.sv
// Shared constants and types for the early/prompt/late code correlator.
// No dependencies; used by the top level and its port checker.
package epl_pkg;

  // Field widths fixed by the interface.
  localparam int SMP_W        = 16;
  localparam int REF_W        = 16;
  localparam int SUM_W        = 32;
  localparam int SIGN_SUM_W   = 16;

  // Default number of significant sample bits.
  localparam int SAMPLE_BITS_DEF = 16;

  // Three replicas, each with an I and a Q sum.
  localparam int NUM_ARMS = 3;
  localparam int NUM_SUMS = 2 * NUM_ARMS;

  // Accumulate mode codes.
  typedef enum logic {
    MODE_SIGN     = 1'b0,
    MODE_MULTIPLY = 1'b1
  } acc_mode_t;

  localparam acc_mode_t MODE_RESET = MODE_MULTIPLY;

  typedef logic signed [REF_W-1:0] ref_t;
  typedef logic signed [SUM_W-1:0] sum_t;

endpackage

### sv/early_prompt_late_correlator.sv
// Early/prompt/late code correlator: six running sums, dumped on the last sample.
// Depends on epl_pkg for widths, mode codes and types.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+------------------------------------------
//   in_     | input     | in_valid/stall   | sample I/Q, six replica weights, last flag
//   out_    | output    | out_valid/stall  | six 32-bit integrated sums
//   cfg_    | input     | cfg_valid/ready  | accumulate mode bit
//
// One transaction is accepted per clock while the input is not stalled. A sample
// passes an input register, then the six multiply-accumulates (or sign-controlled
// adds) run combinationally into the sum registers; on the last sample the updated
// sums load the output register.
// Synchronous active-low reset clears the sums, the valid flags and sets multiply mode.
// The input stalls only while a last sample waits behind an unaccepted result.
module early_prompt_late_correlator #(
  parameter int SAMPLE_BITS = epl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [epl_pkg::SMP_W-1:0]   in_sample_i,
  input  logic signed [epl_pkg::SMP_W-1:0]   in_sample_q,
  input  logic signed [epl_pkg::REF_W-1:0]   in_early_ref_i,
  input  logic signed [epl_pkg::REF_W-1:0]   in_early_ref_q,
  input  logic signed [epl_pkg::REF_W-1:0]   in_prompt_ref_i,
  input  logic signed [epl_pkg::REF_W-1:0]   in_prompt_ref_q,
  input  logic signed [epl_pkg::REF_W-1:0]   in_late_ref_i,
  input  logic signed [epl_pkg::REF_W-1:0]   in_late_ref_q,
  input  logic                               in_last_sample,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [epl_pkg::SUM_W-1:0]   out_early_sum_i,
  output logic signed [epl_pkg::SUM_W-1:0]   out_early_sum_q,
  output logic signed [epl_pkg::SUM_W-1:0]   out_prompt_sum_i,
  output logic signed [epl_pkg::SUM_W-1:0]   out_prompt_sum_q,
  output logic signed [epl_pkg::SUM_W-1:0]   out_late_sum_i,
  output logic signed [epl_pkg::SUM_W-1:0]   out_late_sum_q,
  // Configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_accumulate_mode
);
  import epl_pkg::*;

  // Mode register.
  acc_mode_t mode_r;

  // Input register stage.
  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [SMP_W-1:0] s1_smp_i_r, s1_smp_q_r;
  ref_t                    s1_ref_i_r [NUM_ARMS];
  ref_t                    s1_ref_q_r [NUM_ARMS];
  logic                    s1_last_r;

  // Running sums and the output register.
  sum_t sum_r     [NUM_SUMS];
  sum_t sum_nxt   [NUM_SUMS];
  sum_t out_sum_r [NUM_SUMS];
  logic out_valid_r, out_valid_nxt;

  logic in_accept;
  logic s1_go;

  // Sample reduced to its significant bits, then sign-extended.
  logic signed [SAMPLE_BITS-1:0] smp_i, smp_q;
  logic signed [SIGN_SUM_W-1:0]  smp_i16, smp_q16;
  sum_t                          smp_i32, smp_q32;

  assign smp_i   = s1_smp_i_r[SAMPLE_BITS-1:0];
  assign smp_q   = s1_smp_q_r[SAMPLE_BITS-1:0];
  assign smp_i16 = SIGN_SUM_W'(smp_i);
  assign smp_q16 = SIGN_SUM_W'(smp_q);
  assign smp_i32 = SUM_W'(smp_i);
  assign smp_q32 = SUM_W'(smp_q);

  // Handshake control: a non-last sample always moves on; a last one needs
  // room in the output register.
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Accumulate update: one multiply-accumulate or one 16-bit add/subtract per sum.
  always_comb begin
    logic signed [SIGN_SUM_W-1:0] lo_i, lo_q;
    for (int a = 0; a < NUM_ARMS; a++) begin
      lo_i = '0;
      lo_q = '0;
      unique case (mode_r)
        MODE_MULTIPLY: begin
          sum_nxt[2*a]   = sum_r[2*a]   + smp_i32 * SUM_W'(s1_ref_i_r[a]);
          sum_nxt[2*a+1] = sum_r[2*a+1] + smp_q32 * SUM_W'(s1_ref_q_r[a]);
        end
        MODE_SIGN: begin
          // A negative I weight flips the sample for both sums of the arm.
          if (s1_ref_i_r[a][REF_W-1]) begin
            lo_i = sum_r[2*a][SIGN_SUM_W-1:0]   - smp_i16;
            lo_q = sum_r[2*a+1][SIGN_SUM_W-1:0] - smp_q16;
          end else begin
            lo_i = sum_r[2*a][SIGN_SUM_W-1:0]   + smp_i16;
            lo_q = sum_r[2*a+1][SIGN_SUM_W-1:0] + smp_q16;
          end
          sum_nxt[2*a]   = SUM_W'(lo_i);
          sum_nxt[2*a+1] = SUM_W'(lo_q);
        end
        default: begin
          sum_nxt[2*a]   = sum_r[2*a];
          sum_nxt[2*a+1] = sum_r[2*a+1];
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= acc_mode_t'(cfg_accumulate_mode);
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_smp_i_r    <= in_sample_i;
      s1_smp_q_r    <= in_sample_q;
      s1_ref_i_r[0] <= in_early_ref_i;
      s1_ref_q_r[0] <= in_early_ref_q;
      s1_ref_i_r[1] <= in_prompt_ref_i;
      s1_ref_q_r[1] <= in_prompt_ref_q;
      s1_ref_i_r[2] <= in_late_ref_i;
      s1_ref_q_r[2] <= in_late_ref_q;
      s1_last_r     <= in_last_sample;
    end
  end

  // Running sums: cleared by reset and after each dump.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        sum_r[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        sum_r[k] <= s1_last_r ? '0 : sum_nxt[k];
      end
    end
  end

  // Output register loads the updated sums of the last sample.
  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      for (int k = 0; k < NUM_SUMS; k++) begin
        out_sum_r[k] <= sum_nxt[k];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_early_sum_i  = out_sum_r[0];
  assign out_early_sum_q  = out_sum_r[1];
  assign out_prompt_sum_i = out_sum_r[2];
  assign out_prompt_sum_q = out_sum_r[3];
  assign out_late_sum_i   = out_sum_r[4];
  assign out_late_sum_q   = out_sum_r[5];

endmodule

### sv/epl_checker.sv
// Port-level checks for the early/prompt/late correlator, bound to its top level.
// Depends on epl_pkg for field widths.
module epl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [epl_pkg::SUM_W-1:0] out_early_sum_i,
  input logic signed [epl_pkg::SUM_W-1:0] out_early_sum_q,
  input logic signed [epl_pkg::SUM_W-1:0] out_prompt_sum_i,
  input logic signed [epl_pkg::SUM_W-1:0] out_prompt_sum_q,
  input logic signed [epl_pkg::SUM_W-1:0] out_late_sum_i,
  input logic signed [epl_pkg::SUM_W-1:0] out_late_sum_q,
  input logic                             cfg_ready
);
  import epl_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input only stalls while a result is held back at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // The configuration port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its sums.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_early_sum_i) && $stable(out_early_sum_q) &&
      $stable(out_prompt_sum_i) && $stable(out_prompt_sum_q) &&
      $stable(out_late_sum_i) && $stable(out_late_sum_q)))
    else $error("result payload changed while stalled");

endmodule

bind early_prompt_late_correlator epl_checker u_epl_checker (.*);
